// File: rtl/aac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_pkg: shared types and constants of the activity classifier
// Word formats, register indexes, class codes and control structs.
// ----------------------------------------------------------------------------
package aac_pkg;

	localparam int IDX_W  = 2;
	localparam int DATA_W = 16;

	localparam logic [IDX_W-1:0] REG_REST    = 2'd0;
	localparam logic [IDX_W-1:0] REG_WALK    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SEIZURE = 2'd2;
	localparam logic [IDX_W-1:0] REG_GRAVITY = 2'd3;

	localparam logic [1:0] CLS_REST = 2'd0;
	localparam logic [1:0] CLS_WALK = 2'd1;
	localparam logic [1:0] CLS_RUN  = 2'd2;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  activity_class;
		logic [15:0] average_level;
		logic        seizure_flag;
	} out_word_t;

	// top -> core
	typedef struct packed {
		logic start;   // input word accepted this cycle
		logic take;    // finished average consumed this cycle
	} ctl_t;

	// core -> top
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] average;
	} sts_t;

endpackage

// File: rtl/aac_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_addsub: shared add / subtract-compare unit
// sub=1 gives a-b with carry=1 when a>=b; sub=0 gives a+b.
// ----------------------------------------------------------------------------
module aac_addsub #(
	parameter int W = 18
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         carry
);

	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

// File: rtl/aac_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_ring: magnitude ring storage
// One write and one registered read port; per-entry valid bits make
// never-written entries read as zero.
// ----------------------------------------------------------------------------
module aac_ring #(
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data
);

	logic [15:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [15:0]      rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : 16'd0;

endmodule

// File: rtl/aac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_core: sequencer and datapath
// Squares, bit-pair square root, net magnitude, ring update and a reciprocal
// multiply for the divide by WINDOW, all subtracts going through one shared unit.
// ----------------------------------------------------------------------------
module aac_core import aac_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  in_word_t    in_word,
	input  logic [15:0] gravity_ref,
	output sts_t        sts
);

	localparam int TW = $clog2(WINDOW * 65535 + 1);
	localparam int UW = (TW > 18) ? TW : 18;
	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);
	// floor(total / WINDOW) == (total * RECIP) >> DS for every total below 2**TW
	localparam int DS = TW + $clog2(WINDOW);
	localparam logic [TW:0] RECIP = (TW+1)'((2**DS + WINDOW - 1) / WINDOW);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_ROOT = 4'd2;
	localparam logic [3:0] S_NET  = 4'd3;
	localparam logic [3:0] S_NEG  = 4'd4;
	localparam logic [3:0] S_SUB  = 4'd5;
	localparam logic [3:0] S_ADD  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]    state_q;
	logic [3:0]    cnt_q;
	logic [15:0]   ax_q, ay_q, az_q;
	logic [31:0]   prod_q;
	logic [31:0]   sum_q;
	logic [17:0]   rem_q;
	logic [15:0]   root_q;
	logic [15:0]   net_q;
	logic [TW-1:0] total_q;
	logic [15:0]   quo_q;
	logic [SW-1:0] slot_q;

	logic [15:0]   mul_op;
	logic [31:0]   prod_c;
	logic [17:0]   trial_a;
	logic [15:0]   old_mag;
	logic [2*TW:0] avg_prod;
	logic [UW-1:0] u_a, u_b, u_res;
	logic          u_sub, u_carry;

	function automatic logic [15:0] abs16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mul_op = ax_q;
			2'd1:    mul_op = ay_q;
			default: mul_op = az_q;
		endcase
	end

	assign prod_c   = mul_op * mul_op;
	assign trial_a  = {rem_q[15:0], sum_q[31:30]};
	assign avg_prod = total_q * RECIP;

	// operand select for the shared unit
	always_comb begin
		u_a   = '0;
		u_b   = '0;
		u_sub = 1'b1;
		case (state_q)
			S_ROOT: begin
				u_a = UW'(trial_a);
				u_b = UW'({root_q, 2'b01});
			end
			S_NET: begin
				u_a = UW'(root_q);
				u_b = UW'(gravity_ref);
			end
			S_NEG: begin
				u_a = UW'(gravity_ref);
				u_b = UW'(root_q);
			end
			S_SUB: begin
				u_a = UW'(total_q);
				u_b = UW'(old_mag);
			end
			S_ADD: begin
				u_a   = UW'(total_q);
				u_b   = UW'(net_q);
				u_sub = 1'b0;
			end
			default: begin
				u_sub = 1'b1;
			end
		endcase
	end

	aac_addsub #(.W(UW)) u_addsub (
		.a     (u_a),
		.b     (u_b),
		.sub   (u_sub),
		.res   (u_res),
		.carry (u_carry)
	);

	aac_ring #(.DEPTH(WINDOW), .AW(SW)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctl.start),
		.rd_addr (slot_q),
		.rd_data (old_mag),
		.wr_en   (state_q == S_SUB),
		.wr_addr (slot_q),
		.wr_data (net_q)
	);

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					ax_q  <= abs16(in_word.accel_x);
					ay_q  <= abs16(in_word.accel_y);
					az_q  <= abs16(in_word.accel_z);
					sum_q <= 32'd0;
				end
			end
			S_SQ: begin
				if (cnt_q != 4'd3) begin
					prod_q <= prod_c;
				end
				if (cnt_q != 4'd0) begin
					sum_q <= sum_q + prod_q;
				end
				rem_q  <= 18'd0;
				root_q <= 16'd0;
			end
			S_ROOT: begin
				rem_q  <= u_carry ? u_res[17:0] : trial_a;
				root_q <= {root_q[14:0], u_carry};
				sum_q  <= {sum_q[29:0], 2'b00};
			end
			S_NET: begin
				if (u_carry) begin
					net_q <= u_res[15:0];
				end
			end
			S_NEG: begin
				net_q <= u_res[15:0];
			end
			S_DIV: begin
				quo_q <= avg_prod[DS+15:DS];
			end
			default: begin
			end
		endcase
	end

	// control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 4'd0;
			total_q <= '0;
			slot_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= 4'd0;
					if (ctl.start) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						cnt_q   <= 4'd0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_NET;
					end
				end
				S_NET: begin
					state_q <= u_carry ? S_SUB : S_NEG;
				end
				S_NEG: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					total_q <= u_res[TW-1:0];
					slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
					state_q <= S_ADD;
				end
				S_ADD: begin
					total_q <= u_res[TW-1:0];
					cnt_q   <= 4'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctl.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sts.busy    = (state_q != S_IDLE);
	assign sts.done    = (state_q == S_DONE);
	assign sts.average = quo_q;

endmodule

// File: rtl/accel_activity_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_activity_classifier: accelerometer activity classifier
// Magnitude of a three-axis sample, moving average over WINDOW samples,
// rest / walk / run class and seizure flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                      | word
//  ---------+--------------------------------+----------------------------
//  input    | in_valid / in_stall            | in_word  (accel_x/y/z)
//  output   | out_valid / out_stall          | out_word (class, avg, flag)
//  config   | cfg_we, cfg_index              | cfg_data (16 bit)
//
// Each word goes from its accept through the squares on the 16x16 multiplier,
// 16 root iterations on the shared subtract unit, the net magnitude (plus a
// negate step when the raw magnitude is below gravity_ref), the ring update,
// the reciprocal multiply that divides by WINDOW and the handoff, and only then
// can its result and the next word be accepted.
// in_stall is high from accept until the result moves to the output register;
// a held output word does not block the next accept, only the next result.
// Reset clears control registers, ring valid bits and the running total at once.
// ----------------------------------------------------------------------------
module accel_activity_classifier import aac_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_word,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	logic [15:0] rest_limit_q;
	logic [15:0] walk_limit_q;
	logic [15:0] seizure_limit_q;
	logic [15:0] gravity_ref_q;

	ctl_t       ctl;
	sts_t       sts;
	out_word_t  res_c;
	out_word_t  out_word_q;
	logic       out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_limit_q    <= 16'd819;
			walk_limit_q    <= 16'd4096;
			seizure_limit_q <= 16'd12288;
			gravity_ref_q   <= 16'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REST:    rest_limit_q    <= cfg_data;
				REG_WALK:    walk_limit_q    <= cfg_data;
				REG_SEIZURE: seizure_limit_q <= cfg_data;
				REG_GRAVITY: gravity_ref_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// handshake toward the core
	assign in_stall  = sts.busy;
	assign ctl.start = in_valid && !sts.busy;
	assign ctl.take  = sts.done && (!out_valid_q || !out_stall);

	aac_core #(.WINDOW(WINDOW)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.in_word     (in_word),
		.gravity_ref (gravity_ref_q),
		.sts         (sts)
	);

	// classification: rest first, then walk; flag only in the running class
	always_comb begin
		res_c.average_level = sts.average;
		res_c.seizure_flag  = 1'b0;
		if (sts.average < rest_limit_q) begin
			res_c.activity_class = CLS_REST;
		end else if (sts.average < walk_limit_q) begin
			res_c.activity_class = CLS_WALK;
		end else begin
			res_c.activity_class = CLS_RUN;
			res_c.seizure_flag   = (sts.average > seizure_limit_q);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			out_word_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core not busy after accepting a word");

	a_flag_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.seizure_flag) |-> (out_word.activity_class == CLS_RUN))
		else $error("seizure flag outside running class");

	a_take_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> (!in_stall && out_valid))
		else $error("result handoff did not free the core");

endmodule

// File: dv/accel_activity_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_activity_classifier_test: self-checking bench of the activity classifier
// A short directed set of samples, then bursts of random samples under
// several limit settings. Every accepted sample word is run through a local
// model of the magnitude, ring average and classifier; result words are
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module accel_activity_classifier_test;
	import aac_pkg::*;

	localparam int RING_DEPTH    = 10;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 60;	// margin after the last result word
	localparam int PHASES        = 7;
	localparam int PHASE_WORDS   = 215;
	localparam int DIRECTED_ROWS = 22;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;

	accel_activity_classifier #(
		.WINDOW(RING_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Local copy of the limit registers and of the magnitude ring
	// ------------------------------------------------------------------
	logic [15:0] lim_rest    = 16'd819;
	logic [15:0] lim_walk    = 16'd4096;
	logic [15:0] lim_seizure = 16'd12288;
	logic [15:0] grav_ref    = 16'd8192;

	logic [15:0] ring_copy [RING_DEPTH];
	int          ring_slot = 0;
	logic [19:0] ring_total = '0;

	out_word_t pending_words [$];	// expected result words, oldest first
	int        mismatch_count = 0;
	int        cycle_count = 0;
	bit        calm_in = 1'b0;	// no gaps on the sample side while set

	// Directed samples; the first few have results that are plain to see.
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		bit                 typed;
		out_word_t          res;
	} stim_row_t;

	stim_row_t directed_rows [DIRECTED_ROWS];

	// floor square root, one result bit per pass from the top down
	function automatic logic [15:0] root16(logic [31:0] n);
		logic [15:0] r;
		logic [15:0] c;
		logic [31:0] sq;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			c = r | (16'd1 << b);
			sq = c * c;
			if (sq <= n)
				r = c;
		end
		return r;
	endfunction

	// Net magnitude into the ring, then average and class.
	function automatic out_word_t classify_sample(in_word_t w);
		longint      ax;
		longint      ay;
		longint      az;
		logic [31:0] sq_sum;
		logic [15:0] raw;
		logic [15:0] net;
		logic [19:0] avg20;
		out_word_t   r;
		ax = $signed(w.accel_x);
		ay = $signed(w.accel_y);
		az = $signed(w.accel_z);
		if (ax < 0) ax = -ax;
		if (ay < 0) ay = -ay;
		if (az < 0) az = -az;
		sq_sum = 32'(ax * ax + ay * ay + az * az);
		raw = root16(sq_sum);
		net = (raw >= grav_ref) ? raw - grav_ref : grav_ref - raw;

		ring_total = ring_total - ring_copy[ring_slot] + net;
		ring_copy[ring_slot] = net;
		ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;

		avg20 = ring_total / RING_DEPTH;
		r.average_level = avg20[15:0];
		r.seizure_flag = 1'b0;
		// rest tested first, so walk <= rest leaves no walking band
		if (r.average_level < lim_rest) begin
			r.activity_class = CLS_REST;
		end else if (r.average_level < lim_walk) begin
			r.activity_class = CLS_WALK;
		end else begin
			r.activity_class = CLS_RUN;
			r.seizure_flag = (r.average_level > lim_seizure);
		end
		return r;
	endfunction

	// Random sample; mode picks the kind of motion.
	function automatic in_word_t make_sample(int mode);
		int       comp [3];
		int       lift;
		int       axis;
		in_word_t w;
		if (mode <= 3) begin
			// near 1 g on one axis: resting / light motion
			for (int i = 0; i < 3; i++)
				comp[i] = int'($urandom_range(0, 800)) - 400;
			axis = $urandom_range(0, 2);
			lift = 8192 + int'($urandom_range(0, 1600)) - 800;
			comp[axis] = $urandom_range(0, 1) ? lift : -lift;
		end else if (mode <= 6) begin
			for (int i = 0; i < 3; i++)
				comp[i] = int'($urandom_range(0, 24000)) - 12000;
		end else if (mode <= 8) begin
			for (int i = 0; i < 3; i++)
				comp[i] = $urandom;
		end else begin
			for (int i = 0; i < 3; i++) begin
				case ($urandom_range(0, 5))
					0: comp[i] = -32768;
					1: comp[i] = 32767;
					2: comp[i] = 0;
					3: comp[i] = -1;
					4: comp[i] = 1;
					default: comp[i] = 8192;
				endcase
			end
		end
		w.accel_x = comp[0][15:0];
		w.accel_y = comp[1][15:0];
		w.accel_z = comp[2][15:0];
		return w;
	endfunction

	task automatic report_mismatch(string what, int got, int want_v);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want_v);
		mismatch_count++;
	endtask

	// Offer one sample word; entered and left at a falling edge.
	task automatic send_word(in_word_t w, bit typed, out_word_t typed_want);
		int        gap;
		out_word_t predicted;
		gap = calm_in ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		// accepted at this edge: the model state moves with it
		predicted = classify_sample(w);
		pending_words.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// Block idle: no sample offered and every result word received.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// All four limits written back to back, one per cycle.
	task automatic write_limits(logic [15:0] r, logic [15:0] wk, logic [15:0] s,
			logic [15:0] g);
		cfg_we <= 1'b1;
		cfg_index <= REG_REST;
		cfg_data <= r;
		@(negedge clk);
		cfg_index <= REG_WALK;
		cfg_data <= wk;
		@(negedge clk);
		cfg_index <= REG_SEIZURE;
		cfg_data <= s;
		@(negedge clk);
		cfg_index <= REG_GRAVITY;
		cfg_data <= g;
		@(negedge clk);
		cfg_we <= 1'b0;
		lim_rest = r;
		lim_walk = wk;
		lim_seizure = s;
		grav_ref = g;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall, checked at the accepting edge
	// ------------------------------------------------------------------
	out_word_t want_word;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("result word with none pending", 1, 0);
			end else begin
				want_word = pending_words.pop_front();
				if (out_word.activity_class !== want_word.activity_class)
					report_mismatch("activity_class", out_word.activity_class,
						want_word.activity_class);
				if (out_word.average_level !== want_word.average_level)
					report_mismatch("average_level", out_word.average_level,
						want_word.average_level);
				if (out_word.seizure_flag !== want_word.seizure_flag)
					report_mismatch("seizure_flag", out_word.seizure_flag,
						want_word.seizure_flag);
			end
		end
	end

	initial begin : result_sink
		int hold;
		bit calm_out;
		out_stall = 1'b0;
		calm_out = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0)
				calm_out = !calm_out;
			// some stall before the word shows up as well
			while (!out_valid) begin
				out_stall <= !calm_out && ($urandom_range(0, 3) == 0);
				@(negedge clk);
			end
			hold = calm_out ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int left;
		int burst;
		int mode;
		logic [15:0] r_lim;
		for (int i = 0; i < RING_DEPTH; i++)
			ring_copy[i] = '0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = REG_REST;
		cfg_data = '0;
		arst_n = 1'b0;

		directed_rows = '{
			// ring cleared: net 0 keeps the average at 0
			'{16'sd0, 16'sd0, 16'sd8192, 1'b1, '{CLS_REST, 16'd0, 1'b0}},
			// zero sample: net 8192, average 819 lands on the rest limit
			'{16'sd0, 16'sd0, 16'sd0, 1'b1, '{CLS_WALK, 16'd819, 1'b0}},
			'{16'sd0, 16'sd0, -16'sd8192, 1'b1, '{CLS_WALK, 16'd819, 1'b0}},
			'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
			'{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0},
			'{16'sd0, 16'sd0, 16'sh8000, 1'b0, '0},
			'{16'sd32767, 16'sh8000, 16'sd0, 1'b0, '0},
			'{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
			'{16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
			// raw just below and just above 1 g
			'{16'sd8191, 16'sd0, 16'sd0, 1'b0, '0},
			'{16'sd8193, 16'sd0, 16'sd0, 1'b0, '0},
			// full-scale samples: running class with the seizure flag set throughout
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
			// root of a non-square that floors to exactly 1 g
			'{16'sd5793, 16'sd5793, 16'sd0, 1'b0, '0},
			'{16'sd0, 16'sd0, 16'sd16384, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word('{directed_rows[i].x, directed_rows[i].y, directed_rows[i].z},
				directed_rows[i].typed, directed_rows[i].res);

		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			case (p)
				0: ;	// reset limits
				1: write_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
				2: write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: begin
					// walk below rest: walking band disappears
					r_lim = $urandom_range(3000, 8000);
					write_limits(r_lim, 16'($urandom_range(0, r_lim)),
						16'($urandom_range(0, 30000)), 16'd8192);
				end
				// walking up to the top: flag has to stay low
				4: write_limits(16'h0000, 16'hFFFF, 16'h0000, 16'($urandom_range(0, 16384)));
				5: write_limits(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				default: write_limits(16'd819, 16'd4096, 16'($urandom_range(8000, 30000)),
					16'd8192);
			endcase
			left = PHASE_WORDS;
			while (left > 0) begin
				// bursts of one motion kind let the average settle
				burst = $urandom_range(5, 30);
				mode = $urandom_range(0, 9);
				calm_in = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < burst && left > 0; k++) begin
					send_word(make_sample(mode), 1'b0, '0);
					left--;
				end
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: accel_activity_classifier.f
rtl/aac_pkg.sv
rtl/aac_addsub.sv
rtl/aac_ring.sv
rtl/aac_core.sv
rtl/accel_activity_classifier.sv
dv/accel_activity_classifier_test.sv
